/* hw/rtl/bucketed_window_rate_meter_unit_defines.svh */
// Assertion macros for the bucketed window rate meter checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef BUCKETED_WINDOW_RATE_METER_UNIT_DEFINES_SVH
`define BUCKETED_WINDOW_RATE_METER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define BWRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BWRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bwrm_pkg.sv */
// Shared widths, divider op codes and controller/datapath structs
// for the bucketed window rate meter. No dependencies.
package bwrm_pkg;

  localparam int W_W          = 12;  // window length register
  localparam int ELAPSED_W    = 48;
  localparam int EVENT_W      = 16;
  localparam int RATE_W       = 48;
  localparam int CNT_W        = 32;  // bucket counter
  localparam int FRAC_W       = 16;  // Q32.16 fraction bits
  localparam int BLEN_W       = 41;  // bucket length in ns, worst case 4095e9/2
  localparam int RCP_SH       = 24;  // reciprocal shift for leftover ns per bucket
  localparam int DIV_DW       = ELAPSED_W + 1;  // residue + elapsed
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 48;
  localparam int DEF_NUM_BUCKETS = 25;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // Shared divider operations
  localparam logic [1:0] DIV_OP_BUMP = 2'd1;  // residue / bucket length
  localparam logic [1:0] DIV_OP_AVG  = 2'd2;  // count.16 / window seconds

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       div_start;
    logic [1:0] div_sel;
    logic       blen_load;
    logic       bump_load;
    logic       ring;
    logic       avg_load;
    logic       apply;
    logic       out_load;
  } bwrm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic started;
    logic need_avg;
    logic out_stall;
  } bwrm_sts_t;

endpackage

/* hw/rtl/bwrm_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
// Uses bwrm_pkg for default widths.
module bwrm_div import bwrm_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int VW = BLEN_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          step_o,
  output logic          qbit_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o
);

  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dsr_r, dsr_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // One trial subtraction per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW - 1);
      dvd_nxt  = dividend_i;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor_i;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign step_o      = busy_r;
  assign qbit_o      = ge;
  assign done_o      = done_r;
  assign quotient_o  = quo_r;
  assign remainder_o = rem_r;

endmodule

/* hw/rtl/bwrm_dp.sv */
// Datapath of the rate meter: bucket ring, time residue, average and
// output register. Uses bwrm_pkg and instantiates bwrm_div.
module bwrm_dp import bwrm_pkg::*; #(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bwrm_cmd_t              cmd_i,
  output bwrm_sts_t              sts_o,
  input  logic                   cfg_valid,
  input  logic [W_W-1:0]         cfg_data,
  input  logic                   in_func,
  input  logic [ELAPSED_W-1:0]   in_elapsed,
  input  logic [EVENT_W-1:0]     in_events,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int KW    = $clog2(NUM_BUCKETS + 2);
  localparam int FR_W  = W_W + IDX_W;
  // ns per bucket for a one-second window: whole part and leftover
  localparam int BQ_NS = int'(NS_PER_SEC) / NUM_BUCKETS;
  localparam int BR_NS = int'(NS_PER_SEC) % NUM_BUCKETS;
  // ceil(2^RCP_SH / N), exact for the leftover product range
  localparam int RCP   = ((1 << RCP_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS;

  // Registers
  logic [W_W-1:0]       window_r;
  logic                 func_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [EVENT_W-1:0]   events_r;
  logic [BLEN_W-1:0]    bwhole_r;
  logic [FR_W-1:0]      bfrac_r;
  logic [BLEN_W-1:0]    blen_r;
  logic [BLEN_W-1:0]    residue_r;
  logic [1:0]           op_r;
  logic [IDX_W-1:0]     qmod_r, qmod_nxt;
  logic [KW-1:0]        qsat_r, qsat_nxt;
  logic                 adv_r;
  logic [IDX_W-1:0]     oldest_r, oldest_nxt;
  logic [CNT_W-1:0]     counts_r [NUM_BUCKETS];
  logic [CNT_W-1:0]     counts_nxt [NUM_BUCKETS];
  logic [RATE_W-1:0]    avg_num_r;
  logic [RATE_W-1:0]    average_r;
  logic                 started_r;
  logic                 out_valid_r;
  logic [RATE_W-1:0]    out_rate_r;
  logic                 out_adv_r;

  // Combinational
  logic [W_W-1:0]    eff_w;
  logic [FR_W+RCP_SH-1:0] bfrac_prod;
  logic [BLEN_W-1:0] blen_calc;
  logic [DIV_DW-1:0] div_dividend;
  logic [BLEN_W-1:0] div_divisor;
  logic              div_step, div_qbit, div_done;
  logic [DIV_DW-1:0] div_quo;
  logic [BLEN_W-1:0] div_rem;
  logic [IDX_W:0]    qm2;
  logic [KW:0]       qs2;
  logic [KW:0]       last_sum;
  logic [KW:0]       last_red;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W:0]    old_sum;
  logic              need_avg;

  // A zero window counts as one second
  assign eff_w = (window_r == '0) ? W_W'(1) : window_r;

  // Bucket length: whole part plus leftover ns split by reciprocal multiply
  assign bfrac_prod = (FR_W+RCP_SH)'(bfrac_r) * (FR_W+RCP_SH)'(RCP);
  assign blen_calc  = bwhole_r + BLEN_W'(bfrac_prod[FR_W+RCP_SH-1:RCP_SH]);

  // Operand select for the shared divider
  always_comb begin
    case (cmd_i.div_sel)
      DIV_OP_BUMP: begin
        div_dividend = DIV_DW'(residue_r) + DIV_DW'(elapsed_r);
        div_divisor  = blen_r;
      end
      DIV_OP_AVG: begin
        div_dividend = DIV_DW'(avg_num_r);
        div_divisor  = BLEN_W'(eff_w);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = BLEN_W'(1);
      end
    endcase
  end

  bwrm_div #(
    .DW (DIV_DW),
    .VW (BLEN_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .step_o      (div_step),
    .qbit_o      (div_qbit),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Bump count tracking: quotient mod N and quotient clamped to N+1
  always_comb begin
    qm2      = {qmod_r, div_qbit};
    qs2      = {qsat_r, div_qbit};
    qmod_nxt = qmod_r;
    qsat_nxt = qsat_r;
    if (cmd_i.div_start && cmd_i.div_sel == DIV_OP_BUMP) begin
      qmod_nxt = '0;
      qsat_nxt = '0;
    end else if (div_step && op_r == DIV_OP_BUMP) begin
      qmod_nxt = (qm2 >= (IDX_W+1)'(NUM_BUCKETS))
               ? IDX_W'(qm2 - (IDX_W+1)'(NUM_BUCKETS)) : qm2[IDX_W-1:0];
      qsat_nxt = (qs2 > (KW+1)'(NUM_BUCKETS + 1)) ? KW'(NUM_BUCKETS + 1) : qs2[KW-1:0];
    end
  end

  // Bucket read by the last bump, and the new ring position
  always_comb begin
    last_sum = (KW+1)'(oldest_r) + ((qsat_r == '0) ? '0 : (KW+1)'(qsat_r - KW'(1)));
    last_red = (last_sum >= (KW+1)'(NUM_BUCKETS)) ? last_sum - (KW+1)'(NUM_BUCKETS)
                                                  : last_sum;
    last_idx = last_red[IDX_W-1:0];
    old_sum  = (IDX_W+1)'(oldest_r) + (IDX_W+1)'(qmod_r);
    oldest_nxt = (old_sum >= (IDX_W+1)'(NUM_BUCKETS))
               ? IDX_W'(old_sum - (IDX_W+1)'(NUM_BUCKETS)) : old_sum[IDX_W-1:0];
    need_avg = (qsat_r != '0) && (qsat_r <= KW'(NUM_BUCKETS));
  end

  // Per-bucket update: clear on bumps, saturating add of events
  always_comb begin
    logic [KW-1:0]  off;
    logic [CNT_W:0] sum;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      counts_nxt[b] = counts_r[b];
      off = (IDX_W'(b) >= oldest_r) ? KW'(b) - KW'(oldest_r)
                                    : KW'(b) + KW'(NUM_BUCKETS) - KW'(oldest_r);
      sum = {1'b0, counts_r[b]} + (CNT_W+1)'(events_r);
      if (cmd_i.ring && off < qsat_r) begin
        counts_nxt[b] = '0;
      end else if (cmd_i.apply && func_r) begin
        counts_nxt[b] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      end
    end
  end

  // Control-like state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= W_W'(1);
      residue_r   <= '0;
      oldest_r    <= '0;
      average_r   <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        counts_r[b] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      if (cmd_i.bump_load) begin
        residue_r <= div_rem;
      end
      if (cmd_i.ring) begin
        oldest_r <= oldest_nxt;
        if (qsat_r == KW'(NUM_BUCKETS + 1)) begin
          average_r <= '0;
        end
      end
      if (cmd_i.avg_load) begin
        average_r <= div_quo[RATE_W-1:0];
      end
      if (cmd_i.apply) begin
        started_r <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        counts_r[b] <= counts_nxt[b];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    qmod_r <= qmod_nxt;
    qsat_r <= qsat_nxt;
    if (cmd_i.load_in) begin
      func_r    <= in_func;
      elapsed_r <= in_elapsed;
      events_r  <= in_events;
      adv_r     <= 1'b0;
    end else if (cmd_i.ring) begin
      adv_r <= (qsat_r != '0);
    end
    if (cmd_i.mul) begin
      bwhole_r <= BLEN_W'(eff_w) * BLEN_W'(BQ_NS);
      bfrac_r  <= FR_W'(eff_w) * FR_W'(BR_NS);
    end
    if (cmd_i.div_start) begin
      op_r <= cmd_i.div_sel;
    end
    if (cmd_i.blen_load) begin
      blen_r <= blen_calc;
    end
    if (cmd_i.ring) begin
      avg_num_r <= {counts_r[last_idx], FRAC_W'(0)};
    end
    if (cmd_i.out_load) begin
      out_rate_r <= average_r;
      out_adv_r  <= adv_r;
    end
  end

  always_comb begin
    sts_o.div_done  = div_done;
    sts_o.started   = started_r;
    sts_o.need_avg  = need_avg;
    sts_o.out_stall = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rate_r;
  assign out_tuser  = out_adv_r;

endmodule

/* hw/rtl/bwrm_ctrl.sv */
// Sequencer of the rate meter: steps one request through the shared
// divider and the bucket updates. Uses bwrm_pkg.
module bwrm_ctrl import bwrm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  bwrm_sts_t sts_i,
  output bwrm_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_MUL       = 4'd1;
  localparam logic [3:0] ST_BLEN      = 4'd2;
  localparam logic [3:0] ST_BUMP_GO   = 4'd4;
  localparam logic [3:0] ST_BUMP_WAIT = 4'd5;
  localparam logic [3:0] ST_RING      = 4'd6;
  localparam logic [3:0] ST_AVG_GO    = 4'd7;
  localparam logic [3:0] ST_AVG_WAIT  = 4'd8;
  localparam logic [3:0] ST_APPLY     = 4'd9;
  localparam logic [3:0] ST_OUT       = 4'd10;

  logic [3:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_nxt     = sts_i.started ? ST_MUL : ST_APPLY;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = ST_BLEN;
      end
      ST_BLEN: begin
        cmd_o.blen_load = 1'b1;
        state_nxt       = ST_BUMP_GO;
      end
      ST_BUMP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_OP_BUMP;
        state_nxt       = ST_BUMP_WAIT;
      end
      ST_BUMP_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.bump_load = 1'b1;
          state_nxt       = ST_RING;
        end
      end
      ST_RING: begin
        cmd_o.ring = 1'b1;
        state_nxt  = sts_i.need_avg ? ST_AVG_GO : ST_APPLY;
      end
      ST_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_OP_AVG;
        state_nxt       = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_nxt      = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!sts_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

/* hw/rtl/bucketed_window_rate_meter_unit.sv */
// Bucketed sliding-window event rate meter, top level.
// Uses bwrm_pkg; instantiates bwrm_ctrl and bwrm_dp.
//
// Channels: in_* carries one request (tdata: elapsed_ns, event_count;
// tuser: func). out_* returns one result per request (tdata: rate in
// unsigned Q32.16 events per second; tuser: buckets_advanced).
// cfg_* writes window_seconds; cfg_ready is always high. Write it only
// while no request is in flight.
// Sequence: the first request after reset skips the bucket update and goes
// straight to apply and output. Later requests compute the bucket length in
// the MUL and BLEN states and run the shared 49-step restoring divider once
// for the bump count, plus a second time for the average when the last bump
// reads a live bucket. One request is processed at a time; a new request is
// accepted only once the sequencer is back in idle.
// Reset clears all buckets, the ring index, the residue and the average,
// and sets window_seconds to 1; no clearing pass is needed.
// Stall: the result sits in an output register. A new request is accepted
// while it waits, and that request's result waits in the sequencer until
// out_tready frees the register.
module bucketed_window_rate_meter_unit import bwrm_pkg::*; #(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [W_W-1:0]         cfg_data,    // window_seconds
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [47:0] elapsed_ns, [63:48] event_count
  input  logic                   in_tuser,    // [0] func
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [47:0] rate
  output logic                   out_tuser    // [0] buckets_advanced
);

  bwrm_cmd_t cmd;
  bwrm_sts_t sts;

  assign cfg_ready = 1'b1;

  bwrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bwrm_dp #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_func    (in_tuser),
    .in_elapsed (in_tdata[ELAPSED_W-1:0]),
    .in_events  (in_tdata[ELAPSED_W+EVENT_W-1:ELAPSED_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/bwrm_checker.sv */
// Port-level checker for the rate meter, bound to the top level.
// Uses bwrm_pkg and the macros in bucketed_window_rate_meter_unit_defines.svh.
`include "bucketed_window_rate_meter_unit_defines.svh"

module bwrm_checker import bwrm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [W_W-1:0]         cfg_data,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // stalled result holds
  `BWRM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // one request at a time
  `BWRM_ASSERT_NEXT(a_one_inflight, in_tvalid && in_tready, !in_tready, "request taken while busy")

  // no result appears the cycle after a request is taken
  `BWRM_ASSERT_NEXT(a_min_latency, in_tvalid && in_tready, !$rose(out_tvalid), "result too early")

  // the sequencer returns to idle as it hands off a result
  `BWRM_ASSERT_NOW(a_idle_on_result, $rose(out_tvalid), in_tready, "not idle after result")

endmodule

bind bucketed_window_rate_meter_unit bwrm_checker u_bwrm_checker (.*);

/* tb/tb_bucketed_window_rate_meter_unit.sv */
// Self-checking testbench for the bucketed window rate meter unit.
// Depends on bwrm_pkg and bucketed_window_rate_meter_unit; a local predictor
// mirrors the bucket ring and checks every result in order.
module tb_bucketed_window_rate_meter_unit;
  import bwrm_pkg::*;

  localparam int NB = DEF_NUM_BUCKETS;
  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 4000;     // cycles with no handshake at all
  localparam int END_HOLD = 200;         // hold after the last result before finishing
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES = 8;
  localparam int PLAN_ROWS = 26;

  localparam logic FUNC_TICK = 1'b0;     // advance time only
  localparam logic FUNC_EVENTS = 1'b1;   // advance time, then add events
  localparam logic ROW_REQ = 1'b0;
  localparam logic ROW_CFG = 1'b1;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] BL_1S = 48'd40_000_000;          // bucket of a 1 s window
  localparam logic [47:0] BL_3600S = 48'd144_000_000_000;  // bucket of a 3600 s window

  typedef struct packed {
    logic [47:0] rate;
    logic        advanced;
  } meter_result_t;

  // one line of the directed plan: a request or a window write
  typedef struct packed {
    logic        kind;
    logic [11:0] win;
    logic        func;
    logic [47:0] elapsed;
    logic [15:0] events;
    logic        typed;
    logic [47:0] rate;
    logic        advanced;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [W_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  bucketed_window_rate_meter_unit #(.NUM_BUCKETS(NB)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predictor state, reset values
  logic [31:0] bucket_cnt [NB];
  int unsigned ring_head = 0;
  logic [63:0] ns_residue = '0;
  logic [47:0] avg_q16 = '0;
  bit meter_running = 1'b0;
  logic [11:0] window_sec = 12'd1;

  meter_result_t pending_rates[$];
  int mismatches = 0;
  int stuck_cycles = 0;
  bit idling_on = 1'b1;
  plan_row_t plan [PLAN_ROWS];

  initial begin
    for (int b = 0; b < NB; b++) bucket_cnt[b] = '0;
  end

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic logic [63:0] eff_window();
    return (window_sec == 12'd0) ? 64'd1 : {52'd0, window_sec};
  endfunction

  function automatic logic [63:0] bucket_ns();
    logic [63:0] bl;
    bl = eff_window() * {34'd0, NS_PER_SEC} / NB;
    return (bl == 64'd0) ? 64'd1 : bl;
  endfunction

  // Advance the meter by one request and return the rate it reports
  function automatic meter_result_t advance_meter(input logic f, input logic [47:0] el,
                                                  input logic [15:0] ev);
    meter_result_t r;
    logic [63:0] bl;
    logic [63:0] bumps;
    logic [63:0] k;
    logic [63:0] q;
    logic [32:0] sum;
    r.advanced = 1'b0;
    if (meter_running) begin
      bl = bucket_ns();
      ns_residue = ns_residue + {16'd0, el};
      bumps = ns_residue / bl;
      ns_residue = ns_residue % bl;
      r.advanced = (bumps != 64'd0);
      // more than NB+1 bumps clear everything; the ring still moves the full count
      k = (bumps > NB + 1) ? 64'(NB + 1) : bumps;
      for (longint unsigned i = 0; i < k; i++) begin
        q = ({32'd0, bucket_cnt[ring_head]} << 16) / eff_window();
        avg_q16 = q[47:0];
        bucket_cnt[ring_head] = '0;
        ring_head = (ring_head + 1) % NB;
      end
      ring_head = int'((ring_head + (bumps - k) % NB) % NB);
    end
    meter_running = 1'b1;
    if (f == FUNC_EVENTS) begin
      for (int b = 0; b < NB; b++) begin
        sum = {1'b0, bucket_cnt[b]} + {17'd0, ev};
        bucket_cnt[b] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
    r.rate = avg_q16;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // Drive one request; the expectation is queued at the accepting edge
  task automatic send_req(input logic f, input logic [47:0] el, input logic [15:0] ev,
                          input logic typed, input meter_result_t typed_res);
    meter_result_t r;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ev, el};
    in_tuser <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = advance_meter(f, el, ev);
    pending_rates.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input logic [11:0] w);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_sec = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] pick_elapsed();
    logic [63:0] bl;
    logic [63:0] r64;
    logic [63:0] v;
    bl = bucket_ns();
    r64 = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1, 2, 3: v = r64 % bl;
      4, 5: v = bl * $urandom_range(1, 3) + r64 % bl;
      6: v = bl * $urandom_range(4, 30) + r64 % bl;
      7: v = r64;
      8: v = {16'd0, MAX48};
      default: v = r64 % (bl / 4 + 1);
    endcase
    return v[47:0];
  endfunction

  function automatic logic [15:0] pick_events();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 15));
      default: return r[15:0];
    endcase
  endfunction

  // Result checker: compare each returned rate with the oldest expectation
  always @(posedge clk) begin : check_results
    meter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("result with none pending", '0, out_tdata[47:0]);
      end else begin
        want = pending_rates.pop_front();
        if (out_tdata[47:0] !== want.rate)
          report_mismatch("rate", want.rate, out_tdata[47:0]);
        if (out_tuser !== want.advanced)
          report_mismatch("buckets_advanced", {47'd0, want.advanced}, {47'd0, out_tuser});
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    meter_result_t exp_res;
    logic [11:0] phase_win [NUM_PHASES];
    logic f;

    // first request ignores elapsed; one bucket length then bumps out 65535
    plan[0]  = '{ROW_REQ, 12'd0, FUNC_EVENTS, MAX48, 16'hFFFF, 1'b1, 48'd0, 1'b0};
    plan[1]  = '{ROW_REQ, 12'd0, FUNC_TICK, 48'd0, 16'h1234, 1'b1, 48'd0, 1'b0};
    plan[2]  = '{ROW_REQ, 12'd0, FUNC_TICK, BL_1S - 48'd1, 16'd0, 1'b1, 48'd0, 1'b0};
    plan[3]  = '{ROW_REQ, 12'd0, FUNC_TICK, 48'd1, 16'd0, 1'b1, 48'hFFFF0000, 1'b1};
    plan[4]  = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd0, 16'd0, 1'b1, 48'hFFFF0000, 1'b0};
    plan[5]  = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd0, 16'd1, 1'b0, 48'd0, 1'b0};
    plan[6]  = '{ROW_REQ, 12'd0, FUNC_TICK, BL_1S * 2, 16'd0, 1'b0, 48'd0, 1'b0};
    // a huge gap empties every bucket
    plan[7]  = '{ROW_REQ, 12'd0, FUNC_TICK, MAX48, 16'd0, 1'b1, 48'd0, 1'b1};
    // zero window behaves as one second
    plan[8]  = '{ROW_CFG, 12'd0, FUNC_TICK, 48'd0, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[9]  = '{ROW_REQ, 12'd0, FUNC_EVENTS, BL_1S / 2, 16'd300, 1'b0, 48'd0, 1'b0};
    plan[10] = '{ROW_REQ, 12'd0, FUNC_TICK, BL_1S, 16'd0, 1'b0, 48'd0, 1'b0};
    // long window builds a residue, then a short window bumps it all at once
    plan[11] = '{ROW_CFG, 12'd4095, FUNC_TICK, 48'd0, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[12] = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd100_000_000_000, 16'hFFFF, 1'b0, 48'd0,
                 1'b0};
    plan[13] = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd0, 16'd1000, 1'b0, 48'd0, 1'b0};
    plan[14] = '{ROW_CFG, 12'd1, FUNC_TICK, 48'd0, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[15] = '{ROW_REQ, 12'd0, FUNC_TICK, 48'd0, 16'd0, 1'b1, 48'd0, 1'b1};
    // truncating division, then bump counts around the clear-all boundary
    plan[16] = '{ROW_CFG, 12'd3600, FUNC_TICK, 48'd0, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[17] = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd0, 16'd7, 1'b0, 48'd0, 1'b0};
    plan[18] = '{ROW_REQ, 12'd0, FUNC_TICK, BL_3600S, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[19] = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd5, 16'hFFFF, 1'b0, 48'd0, 1'b0};
    plan[20] = '{ROW_REQ, 12'd0, FUNC_TICK, BL_3600S * 25, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[21] = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd0, 16'hFFFF, 1'b0, 48'd0, 1'b0};
    plan[22] = '{ROW_REQ, 12'd0, FUNC_TICK, BL_3600S * 26, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[23] = '{ROW_REQ, 12'd0, FUNC_EVENTS, 48'd1, 16'hFFFF, 1'b0, 48'd0, 1'b0};
    plan[24] = '{ROW_REQ, 12'd0, FUNC_TICK, BL_3600S * 27 + 48'd1, 16'd0, 1'b0, 48'd0, 1'b0};
    plan[25] = '{ROW_CFG, 12'd1, FUNC_TICK, 48'd0, 16'd0, 1'b0, 48'd0, 1'b0};

    phase_win[0] = 12'd1;
    phase_win[1] = 12'd4095;
    phase_win[2] = 12'd0;
    phase_win[3] = 12'd3600;
    phase_win[4] = 12'($urandom_range(1, 4095));
    phase_win[5] = 12'd2;
    phase_win[6] = 12'($urandom_range(1, 4095));
    phase_win[7] = 12'd1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed plan
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_window(plan[i].win);
      end else begin
        exp_res.rate = plan[i].rate;
        exp_res.advanced = plan[i].advanced;
        send_req(plan[i].func, plan[i].elapsed, plan[i].events, plan[i].typed, exp_res);
      end
    end

    // random phases, one window setting each; the last one runs without idling
    exp_res = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_window(phase_win[p]);
      idling_on = (p != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) == 0) wait_drained();
        f = ($urandom_range(0, 9) < 7) ? FUNC_EVENTS : FUNC_TICK;
        send_req(f, pick_elapsed(), pick_events(), 1'b0, exp_res);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (END_HOLD) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/bwrm_pkg.sv
hw/rtl/bwrm_div.sv
hw/rtl/bwrm_dp.sv
hw/rtl/bwrm_ctrl.sv
hw/rtl/bucketed_window_rate_meter_unit.sv
hw/rtl/bwrm_checker.sv
tb/tb_bucketed_window_rate_meter_unit.sv
